// File: src/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int DATA_W       = 64;
    localparam int COUNT_W      = 7;
    localparam int KIND_W       = 3;
    localparam int CURSOR_OUT_W = 13;
    localparam int USED_OUT_W   = 10;

    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PAD     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REWIND  = 3'd4;

    localparam logic [COUNT_W-1:0] MAX_COUNT = 7'd64;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_dp_status;

    function automatic logic [DATA_W-1:0] count_mask(input logic [COUNT_W-1:0] count);
        logic [DATA_W-1:0] m;
        if (count >= MAX_COUNT) begin
            m = '1;
        end else begin
            m = (64'd1 << count[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

// File: src/lbp_ctrl.sv
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer: clearing pass after reset, then accept / execute per command.
// ----------------------------------------------------------------------------
module lbp_ctrl
    import lbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/lbp_datapath.sv
// ----------------------------------------------------------------------------
// lbp_datapath
// Two-bank word store, bit cursor, used size and the merge/extract logic.
// ----------------------------------------------------------------------------
module lbp_datapath
    import lbp_pkg::*;
#(
    parameter int CAPACITY_BYTES = 512
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic [COUNT_W-1:0]      i_bit_count,
    input  logic [DATA_W-1:0]       i_write_data,
    output t_dp_status              o_status,
    output logic                    o_valid,
    output logic [DATA_W-1:0]       o_read_data,
    output logic                    o_ok,
    output logic [CURSOR_OUT_W-1:0] o_cursor_bits,
    output logic [USED_OUT_W-1:0]   o_used_bytes,
    output logic [CURSOR_OUT_W-1:0] o_remaining_bits
);

    localparam int NWORDS = (CAPACITY_BYTES + 7) / 8;
    localparam int BD     = (NWORDS + 1) / 2;
    localparam int AW     = (BD > 1) ? $clog2(BD) : 1;
    localparam int CW     = $clog2(CAPACITY_BYTES * 8 + 1);
    localparam int UW     = $clog2(CAPACITY_BYTES + 1);
    localparam int XW     = CW + 1;

    logic [DATA_W-1:0] mem_even [BD];
    logic [DATA_W-1:0] mem_odd  [BD];

    logic [CW-1:0]      r_cursor;
    logic [UW-1:0]      r_used;
    logic [AW-1:0]      r_clr_addr;
    logic [KIND_W-1:0]  r_kind;
    logic [COUNT_W-1:0] r_count;
    logic [DATA_W-1:0]  r_data;
    logic [AW-1:0]      r_addr_even;
    logic [AW-1:0]      r_addr_odd;
    logic               r_even_ok;
    logic               r_odd_ok;
    logic               r_lo_odd;
    logic [DATA_W-1:0]  r_rd_even;
    logic [DATA_W-1:0]  r_rd_odd;

    logic                    r_valid;
    logic [DATA_W-1:0]       r_out_rd;
    logic                    r_out_ok;
    logic [CURSOR_OUT_W-1:0] r_out_cursor;
    logic [USED_OUT_W-1:0]   r_out_used;
    logic [CURSOR_OUT_W-1:0] r_out_rem;

    logic [CW-1:0] n_cursor;
    logic [UW-1:0] n_used;

    // word addresses for the access at the current cursor
    logic [31:0] w_word;
    logic [31:0] w_ae32;
    logic [31:0] w_ao32;

    always_comb begin
        w_word = 32'(r_cursor[CW-1:6]);
        w_ao32 = w_word >> 1;
        w_ae32 = w_word[0] ? (w_ao32 + 32'd1) : w_ao32;
    end

    // execute-cycle logic
    logic [XW-1:0]         w_sum;
    logic [XW-1:0]         w_lim;
    logic                  w_fit;
    logic [UW:0]           w_grown;
    logic                  w_cap_ok;
    logic                  w_ok;
    logic                  w_we;
    logic                  w_rd_en;
    logic [DATA_W-1:0]     w_mask;
    logic [2*DATA_W-1:0]   w_win;
    logic [2*DATA_W-1:0]   w_shift;
    logic [2*DATA_W-1:0]   w_wmask;
    logic [2*DATA_W-1:0]   w_wdat;
    logic [2*DATA_W-1:0]   w_merged;
    logic [DATA_W-1:0]     w_rd;
    logic [DATA_W-1:0]     w_wr_even;
    logic [DATA_W-1:0]     w_wr_odd;
    logic [31:0]           w_c32;
    logic [31:0]           w_u32;
    logic [31:0]           w_rem32;

    always_comb begin
        w_sum    = {1'b0, r_cursor} + XW'(r_count);
        w_lim    = XW'({r_used, 3'b000});
        w_fit    = (w_sum <= w_lim);
        w_grown  = {1'b0, r_used} + (UW+1)'(r_count >> 3) + (UW+1)'(1);
        w_cap_ok = (w_grown <= (UW+1)'(CAPACITY_BYTES));

        n_cursor = r_cursor;
        n_used   = r_used;
        w_ok     = 1'b0;
        w_we     = 1'b0;
        w_rd_en  = 1'b0;
        case (r_kind)
            KIND_WRITE, KIND_PAD: begin
                w_ok = w_fit || w_cap_ok;
                if (w_ok) begin
                    n_cursor = w_sum[CW-1:0];
                    if (!w_fit) begin
                        n_used = w_grown[UW-1:0];
                    end
                end
                w_we = w_ok && (r_kind == KIND_WRITE);
            end
            KIND_READ, KIND_DISCARD: begin
                w_ok = w_fit;
                if (w_fit) begin
                    n_cursor = w_sum[CW-1:0];
                end
                w_rd_en = w_fit && (r_kind == KIND_READ);
            end
            KIND_REWIND: begin
                w_ok     = 1'b1;
                n_cursor = '0;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase

        w_mask   = count_mask(r_count);
        w_win    = r_lo_odd ? {r_rd_even, r_rd_odd} : {r_rd_odd, r_rd_even};
        w_shift  = w_win >> r_cursor[5:0];
        w_rd     = w_rd_en ? (w_shift[DATA_W-1:0] & w_mask) : '0;
        w_wmask  = {{DATA_W{1'b0}}, w_mask} << r_cursor[5:0];
        w_wdat   = {{DATA_W{1'b0}}, r_data & w_mask} << r_cursor[5:0];
        w_merged = (w_win & ~w_wmask) | w_wdat;
        w_wr_even = r_lo_odd ? w_merged[2*DATA_W-1:DATA_W] : w_merged[DATA_W-1:0];
        w_wr_odd  = r_lo_odd ? w_merged[DATA_W-1:0] : w_merged[2*DATA_W-1:DATA_W];

        w_c32   = 32'(n_cursor);
        w_u32   = 32'(n_used);
        w_rem32 = (w_u32 << 3) - w_c32;
    end

    // memory banks: clear sweep after reset, read on load, write back on execute
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_even[r_clr_addr] <= '0;
            mem_odd[r_clr_addr]  <= '0;
        end else if (i_cmd.exec && w_we) begin
            if (r_even_ok) begin
                mem_even[r_addr_even] <= w_wr_even;
            end
            if (r_odd_ok) begin
                mem_odd[r_addr_odd] <= w_wr_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (w_ae32 < 32'(BD)) begin
                r_rd_even <= mem_even[w_ae32[AW-1:0]];
            end
            if (w_ao32 < 32'(BD)) begin
                r_rd_odd <= mem_odd[w_ao32[AW-1:0]];
            end
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= i_kind;
            r_count     <= (i_bit_count > MAX_COUNT) ? MAX_COUNT : i_bit_count;
            r_data      <= i_write_data;
            r_addr_even <= w_ae32[AW-1:0];
            r_addr_odd  <= w_ao32[AW-1:0];
            r_even_ok   <= (w_ae32 < 32'(BD));
            r_odd_ok    <= (w_ao32 < 32'(BD));
            r_lo_odd    <= w_word[0];
        end
    end

    // cursor, used size, clear counter, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_used     <= '0;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.exec) begin
                r_cursor <= n_cursor;
                r_used   <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_rd     <= w_rd;
            r_out_ok     <= w_ok;
            r_out_cursor <= w_c32[CURSOR_OUT_W-1:0];
            r_out_used   <= w_u32[USED_OUT_W-1:0];
            r_out_rem    <= w_rem32[CURSOR_OUT_W-1:0];
        end
    end

    assign o_status.clear_last = (r_clr_addr == AW'(BD - 1));
    assign o_valid          = r_valid;
    assign o_read_data      = r_out_rd;
    assign o_ok             = r_out_ok;
    assign o_cursor_bits    = r_out_cursor;
    assign o_used_bytes     = r_out_used;
    assign o_remaining_bits = r_out_rem;

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.exec) && !(i_cmd.clear && i_cmd.exec))
        else $error("load, clear and execute overlap");

    a_strobe_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_valid)
        else $error("result strobe missing after execute");

    a_cursor_in_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cursor} <= w_lim)
        else $error("cursor beyond used size");

    a_refused_keeps_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !w_ok) |=> (r_used == $past(r_used) && r_cursor == $past(r_cursor)))
        else $error("refused transfer changed state");

endmodule

// File: src/lsb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_top
// Bit-granular byte store with one shared LSB-first bit cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_kind, i_bit_count and i_write_data with start
//   high; the transfer is taken at the rising edge where busy is low.
//   Kinds: write, pad write, read, discard read, rewind cursor.
//   Result channel: o_valid is high for exactly one cycle, once the command
//   has passed the execute state and the result registers, with read data,
//   ok flag, cursor, used size and remaining bits. The receiver cannot
//   stall; it must take each result. Steps: when a command is taken, the two
//   adjacent 64-bit words around the cursor are read from the even and odd
//   memory banks; the execute state then merges or extracts and writes back.
//   busy is high during the execute state, so a new command may follow once
//   it ends, overlapping the result strobe of the previous one.
//   Reset: i_rst_n clears cursor and used size, then a clearing pass zeroes
//   the store one word per bank per cycle, with busy high throughout.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_top
    import lbp_pkg::*;
#(
    parameter int CAPACITY_BYTES = 512
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic [COUNT_W-1:0]      i_bit_count,
    input  logic [DATA_W-1:0]       i_write_data,
    output logic                    o_valid,
    output logic [DATA_W-1:0]       o_read_data,
    output logic                    o_ok,
    output logic [CURSOR_OUT_W-1:0] o_cursor_bits,
    output logic [USED_OUT_W-1:0]   o_used_bytes,
    output logic [CURSOR_OUT_W-1:0] o_remaining_bits
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    lbp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    lbp_datapath #(
        .CAPACITY_BYTES (CAPACITY_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_kind           (i_kind),
        .i_bit_count      (i_bit_count),
        .i_write_data     (i_write_data),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_read_data      (o_read_data),
        .o_ok             (o_ok),
        .o_cursor_bits    (o_cursor_bits),
        .o_used_bytes     (o_used_bytes),
        .o_remaining_bits (o_remaining_bits)
    );

endmodule

// File: sim/tb_lsb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_packer_top
// Self-checking bench for the LSB-first bit packer. It sends directed and
// randomized commands (write, pad, read, discard, rewind and unknown kinds)
// with random idle gaps. A bit-level copy of the store predicts each result,
// and the result strobe is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer_top;
    import lbp_pkg::*;

    localparam int CAPACITY    = 512;
    localparam int STORE_BITS  = CAPACITY * 8;
    localparam int RANDOM_CMDS = 1200;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 10;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic [DATA_W-1:0]  data;
        logic [7:0]         idle_cycles;
        logic               drain_first;
    } t_packer_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]       rd;
        logic                    ok;
        logic [CURSOR_OUT_W-1:0] cursor;
        logic [USED_OUT_W-1:0]   used;
        logic [CURSOR_OUT_W-1:0] remain;
    } t_packer_status;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [KIND_W-1:0]       i_kind = KIND_WRITE;
    logic [COUNT_W-1:0]      i_bit_count = '0;
    logic [DATA_W-1:0]       i_write_data = '0;
    logic                    o_valid;
    logic [DATA_W-1:0]       o_read_data;
    logic                    o_ok;
    logic [CURSOR_OUT_W-1:0] o_cursor_bits;
    logic [USED_OUT_W-1:0]   o_used_bytes;
    logic [CURSOR_OUT_W-1:0] o_remaining_bits;

    lsb_first_bit_packer_top #(
        .CAPACITY_BYTES(CAPACITY)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_bit_count     (i_bit_count),
        .i_write_data    (i_write_data),
        .o_valid         (o_valid),
        .o_read_data     (o_read_data),
        .o_ok            (o_ok),
        .o_cursor_bits   (o_cursor_bits),
        .o_used_bytes    (o_used_bytes),
        .o_remaining_bits(o_remaining_bits)
    );

    t_packer_cmd    pending_cmds[$];
    t_packer_status expected_status[$];
    t_packer_cmd    cmd_on_bus;
    t_packer_cmd    next_cmd;

    // shadow of the store, one entry per bit
    bit  shadow_bits [0:STORE_BITS-1];
    int  shadow_cursor = 0;
    int  shadow_used = 0;

    int  idle_left = 0;
    bit  gap_taken = 1'b0;
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  gappy = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_packer_status apply_packer_cmd(t_packer_cmd c);
        t_packer_status r;
        int  n;
        int  i;
        bit  fits;
        n = (c.count > MAX_COUNT) ? 64 : int'(c.count);
        r.rd = '0;
        r.ok = 1'b0;
        case (c.kind)
            KIND_WRITE, KIND_PAD: begin
                fits = 1'b1;
                if (shadow_cursor + n > shadow_used * 8) begin
                    if (shadow_used + n / 8 + 1 > CAPACITY) begin
                        fits = 1'b0;
                    end else begin
                        shadow_used = shadow_used + n / 8 + 1;
                    end
                end
                if (fits) begin
                    if (c.kind == KIND_WRITE) begin
                        for (i = 0; i < n; i++) begin
                            if (shadow_cursor + i < STORE_BITS) begin
                                shadow_bits[shadow_cursor + i] = c.data[i];
                            end
                        end
                    end
                    shadow_cursor = shadow_cursor + n;
                    r.ok = 1'b1;
                end
            end
            KIND_READ, KIND_DISCARD: begin
                if (shadow_cursor + n <= shadow_used * 8) begin
                    if (c.kind == KIND_READ) begin
                        for (i = 0; i < n; i++) begin
                            r.rd[i] = shadow_bits[shadow_cursor + i];
                        end
                    end
                    shadow_cursor = shadow_cursor + n;
                    r.ok = 1'b1;
                end
            end
            KIND_REWIND: begin
                shadow_cursor = 0;
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.cursor = shadow_cursor[CURSOR_OUT_W-1:0];
        r.used   = shadow_used[USED_OUT_W-1:0];
        r.remain = CURSOR_OUT_W'(shadow_used * 8 - shadow_cursor);
        return r;
    endfunction

    function automatic logic [7:0] pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gappy || roll < 70) begin
            return 8'd0;
        end else if (roll < 95) begin
            return 8'($urandom_range(1, 3));
        end
        return 8'($urandom_range(8, 40));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            return MAX_COUNT;
        end else if (roll < 15) begin
            return COUNT_W'($urandom_range(65, 127));
        end else if (roll < 25) begin
            return COUNT_W'($urandom_range(0, 3));
        end
        return COUNT_W'($urandom_range(0, 64));
    endfunction

    function automatic logic [DATA_W-1:0] pick_data();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return '1;
        end else if (roll == 1) begin
            return '0;
        end
        return {$urandom, $urandom};
    endfunction

    task automatic add_cmd(logic [KIND_W-1:0] kind, logic [COUNT_W-1:0] count,
                           logic [DATA_W-1:0] data, bit drain);
        t_packer_cmd c;
        c.kind        = kind;
        c.count       = count;
        c.data        = data;
        c.idle_cycles = pick_gap();
        c.drain_first = drain;
        pending_cmds.push_back(c);
    endtask

    task automatic build_random_cmds();
        int added;
        int span;
        int mode;
        int k;
        int roll;
        added = 0;
        // open with a long fill so the store runs into its capacity early
        for (k = 0; k < 90; k++) begin
            add_cmd(($urandom_range(0, 4) == 0) ? KIND_PAD : KIND_WRITE,
                    COUNT_W'($urandom_range(40, 64)), pick_data(), 1'b0);
        end
        added = 90;
        while (added < RANDOM_CMDS) begin
            if ($urandom_range(0, 2) == 0) begin
                gappy = ~gappy;
            end
            mode = $urandom_range(0, 9);
            span = (mode == 9) ? $urandom_range(1, 8) : $urandom_range(10, 50);
            for (k = 0; k < span; k++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0, 1, 2: begin
                        add_cmd((roll < 75) ? KIND_WRITE : (roll < 90) ? KIND_PAD : KIND_READ,
                                pick_count(), pick_data(), 1'b0);
                    end
                    3, 4, 5: begin
                        if (k == 0) begin
                            add_cmd(KIND_REWIND, pick_count(), pick_data(), 1'b0);
                        end else begin
                            add_cmd((roll < 70) ? KIND_READ : KIND_DISCARD,
                                    pick_count(), pick_data(), 1'b0);
                        end
                    end
                    6, 7, 8: begin
                        add_cmd((roll < 5) ? KIND_REWIND : KIND_W'($urandom_range(0, 3)),
                                pick_count(), pick_data(), 1'b0);
                    end
                    default: begin
                        add_cmd(KIND_W'($urandom_range(0, 7)), COUNT_W'($urandom_range(0, 127)),
                                {$urandom, $urandom}, 1'b0);
                    end
                endcase
            end
            added = added + span;
            // hold the sender now and then until the block has fully drained
            if ($urandom_range(0, 5) == 0) begin
                pending_cmds[pending_cmds.size() - 1].drain_first = 1'b1;
            end
        end
    endtask

    // driver: one transfer per start && !busy edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
            gap_taken <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_status.push_back(apply_packer_cmd(cmd_on_bus));
            end
            if (start && busy) begin
                // hold the command until the block takes it
            end else if (idle_left > 0) begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].drain_first && expected_status.size() != 0)) begin
                if (!gap_taken && pending_cmds[0].idle_cycles != 0) begin
                    start     <= 1'b0;
                    idle_left <= int'(pending_cmds[0].idle_cycles) - 1;
                    gap_taken <= 1'b1;
                end else begin
                    next_cmd = pending_cmds.pop_front();
                    cmd_on_bus   <= next_cmd;
                    i_kind       <= next_cmd.kind;
                    i_bit_count  <= next_cmd.count;
                    i_write_data <= next_cmd.data;
                    start        <= 1'b1;
                    gap_taken    <= 1'b0;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, so check every strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_status.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) begin
                    $display("unexpected result: rd=%h ok=%b cur=%0d used=%0d rem=%0d",
                             o_read_data, o_ok, o_cursor_bits, o_used_bytes,
                             o_remaining_bits);
                end
            end else begin
                t_packer_status e;
                e = expected_status.pop_front();
                if (o_read_data !== e.rd || o_ok !== e.ok || o_cursor_bits !== e.cursor ||
                    o_used_bytes !== e.used || o_remaining_bits !== e.remain) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp rd=%h ok=%b cur=%0d used=%0d rem=%0d",
                                 e.rd, e.ok, e.cursor, e.used, e.remain);
                        $display("          got rd=%h ok=%b cur=%0d used=%0d rem=%0d",
                                 o_read_data, o_ok, o_cursor_bits, o_used_bytes,
                                 o_remaining_bits);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_lsb_first_bit_packer_top NOT OK");
            $finish;
        end
    end

    initial begin
        for (int b = 0; b < STORE_BITS; b++) begin
            shadow_bits[b] = 1'b0;
        end

        // empty store: zero-length read, reads past size
        add_cmd(KIND_READ,    7'd0,   '1, 1'b0);
        add_cmd(KIND_READ,    7'd1,   '0, 1'b0);
        add_cmd(KIND_DISCARD, 7'd8,   '0, 1'b0);
        add_cmd(KIND_DISCARD, 7'd0,   '0, 1'b0);
        // full-width writes, zero count, count above 64
        add_cmd(KIND_WRITE,   7'd64,  '1, 1'b0);
        add_cmd(KIND_WRITE,   7'd0,   64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
        add_cmd(KIND_WRITE,   7'd127, 64'h0123_4567_89AB_CDEF, 1'b0);
        add_cmd(KIND_PAD,     7'd3,   '1, 1'b0);
        add_cmd(KIND_WRITE,   7'd5,   64'hFFFF_FFFF_FFFF_FFF6, 1'b0);
        add_cmd(KIND_WRITE,   7'd1,   64'h1, 1'b0);
        add_cmd(KIND_PAD,     7'd64,  '0, 1'b0);
        add_cmd(KIND_DISCARD, 7'd15,  '0, 1'b0);
        add_cmd(KIND_READ,    7'd1,   '0, 1'b0);
        // read back from the start
        add_cmd(KIND_REWIND,  7'd0,   '0, 1'b1);
        add_cmd(KIND_READ,    7'd64,  '0, 1'b0);
        add_cmd(KIND_READ,    7'd65,  '1, 1'b0);
        add_cmd(KIND_READ,    7'd13,  '0, 1'b0);
        add_cmd(KIND_DISCARD, 7'd7,   '0, 1'b0);
        // unknown kinds are refused
        add_cmd(3'd5,         7'd64,  '1, 1'b0);
        add_cmd(3'd6,         7'd100, 64'hDEAD_BEEF_0BAD_F00D, 1'b0);
        add_cmd(3'd7,         7'd127, '1, 1'b0);
        add_cmd(KIND_REWIND,  7'd127, '1, 1'b1);
        add_cmd(KIND_READ,    7'd127, '0, 1'b0);
        add_cmd(KIND_WRITE,   7'd64,  '0, 1'b0);
        add_cmd(KIND_REWIND,  7'd0,   '0, 1'b0);
        add_cmd(KIND_READ,    7'd64,  '0, 1'b0);

        build_random_cmds();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start) begin
            @(posedge i_clk);
        end
        while (expected_status.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        // a result still owed after the tail counts as lost
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("tb_lsb_first_bit_packer_top OK");
        end else begin
            $display("tb_lsb_first_bit_packer_top NOT OK");
        end
        $finish;
    end

endmodule
